// ===== src/obse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package obse_pkg;
	localparam int TICKER_COUNT_DEF = 8;
	localparam int SLOTS_PER_TICKER_DEF = 1024;

	localparam logic [2:0] MK_START  = 3'd0;
	localparam logic [2:0] MK_CLEAR  = 3'd1;
	localparam logic [2:0] MK_ADD    = 3'd2;
	localparam logic [2:0] MK_END    = 3'd3;
	localparam logic [2:0] MK_STATUS = 3'd4;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_EXISTS  = 3'd1;
	localparam logic [2:0] ST_MISSING = 3'd2;
	localparam logic [2:0] ST_SIDE    = 3'd3;
	localparam logic [2:0] ST_GAP     = 3'd4;
	localparam logic [2:0] ST_BUSY    = 3'd5;

	localparam logic [1:0] UK_ADD    = 2'd0;
	localparam logic [1:0] UK_MODIFY = 2'd1;
	localparam logic [1:0] UK_CANCEL = 2'd2;
	localparam logic [1:0] UK_OTHER  = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic clr_we;      // clearing pass write
		logic rd;          // read entry at current address
		logic upd_wr;      // commit update (if checks pass)
		logic upd_resp;    // load status response
		logic busy_resp;   // load busy response
		logic emit_start;
		logic emit_clear;
		logic emit_add;
		logic emit_end;
		logic cur_reset;   // ticker and slot to zero
		logic slot_reset;  // slot to zero
		logic slot_inc;
		logic tick_inc;
		logic use_cursor;  // address from cursor instead of item
		logic clr_inc;
	} obse_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_done;
		logic rd_valid;     // entry read last cycle is live
		logic slot_last;    // cursor slot is the last of its ticker
		logic tick_last;
	} obse_sts_t;
endpackage
`default_nettype wire

// ===== src/obse_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module obse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== src/obse_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module obse_datapath #(
	parameter int TICKER_COUNT = obse_pkg::TICKER_COUNT_DEF,
	parameter int SLOTS_PER_TICKER = obse_pkg::SLOTS_PER_TICKER_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire obse_pkg::obse_cmd_t cmd,
	output obse_pkg::obse_sts_t     sts,
	input  wire logic               load_in,
	input  wire logic [1:0]         update_kind,
	input  wire logic [2:0]         ticker,
	input  wire logic [9:0]         order_slot,
	input  wire logic               side,
	input  wire logic [31:0]        price,
	input  wire logic [31:0]        quantity,
	input  wire logic [31:0]        priority_req,
	input  wire logic [31:0]        sequence_req,
	output logic [31:0]             message_number,
	output logic [2:0]              message_kind,
	output logic [2:0]              out_ticker,
	output logic [9:0]              out_order_slot,
	output logic                    out_side,
	output logic [31:0]             out_price,
	output logic [31:0]             out_quantity,
	output logic [31:0]             out_priority,
	output logic [31:0]             last_sequence,
	output logic [2:0]              status,
	output logic                    last
);
	localparam int TW = (TICKER_COUNT > 1) ? $clog2(TICKER_COUNT) : 1;
	localparam int SW = $clog2(SLOTS_PER_TICKER);
	localparam int DEPTH = TICKER_COUNT * SLOTS_PER_TICKER;
	localparam int AW = $clog2(DEPTH);
	// memory word: valid, side, price, priority, quantity
	localparam int MW = 98;

	logic [1:0]  kind_q;
	logic [7:0]  tick_in_q;
	logic [9:0]  slot_in_q;
	logic        side_q;
	logic [31:0] price_q, qty_q, prio_q, seq_q;
	logic [31:0] applied_q, count_q;
	logic [TW-1:0] cur_t_q;
	logic [SW-1:0] cur_s_q;
	logic [AW:0]   clr_q;

	logic          in_range;
	logic [AW-1:0] item_addr, port_addr, cur_addr, cur_next, raddr, waddr;
	logic [MW-1:0] rdata, wdata;
	logic          we;
	logic [2:0]    chk;

	always_ff @(posedge clk) begin
		if (load_in) begin
			kind_q    <= update_kind;
			tick_in_q <= 8'(ticker);
			slot_in_q <= order_slot;
			side_q    <= side;
			price_q   <= price;
			qty_q     <= quantity;
			prio_q    <= priority_req;
			seq_q     <= sequence_req;
		end
	end

	assign in_range = (32'(tick_in_q) < 32'(TICKER_COUNT))
		&& (32'(slot_in_q) < 32'(SLOTS_PER_TICKER));
	assign item_addr = in_range
		? AW'(32'(tick_in_q) * 32'(SLOTS_PER_TICKER) + 32'(slot_in_q)) : '0;
	// entry of the item on the ports, read at the edge that takes it
	assign port_addr = ((32'(ticker) < 32'(TICKER_COUNT))
		&& (32'(order_slot) < 32'(SLOTS_PER_TICKER)))
		? AW'(32'(ticker) * 32'(SLOTS_PER_TICKER) + 32'(order_slot)) : '0;
	assign cur_addr = AW'(32'(cur_t_q) * 32'(SLOTS_PER_TICKER) + 32'(cur_s_q));
	assign cur_next = AW'(32'(cur_t_q) * 32'(SLOTS_PER_TICKER) + 32'(cur_s_q) + 32'd1);
	// a skip step reads the slot the cursor moves to
	assign raddr = cmd.use_cursor ? (cmd.slot_inc ? cur_next : cur_addr)
		: (cmd.rd ? port_addr : item_addr);

	always_comb begin
		chk = obse_pkg::ST_OK;
		if (kind_q != obse_pkg::UK_OTHER) begin
			if (!in_range) begin
				chk = obse_pkg::ST_MISSING;
			end else if (kind_q == obse_pkg::UK_ADD) begin
				if (rdata[97]) chk = obse_pkg::ST_EXISTS;
			end else if (!rdata[97]) begin
				chk = obse_pkg::ST_MISSING;
			end else if (rdata[96] != side_q) begin
				chk = obse_pkg::ST_SIDE;
			end
		end
		if (chk == obse_pkg::ST_OK && seq_q != applied_q + 32'd1) chk = obse_pkg::ST_GAP;
	end

	always_comb begin
		wdata = '0;
		we    = 1'b0;
		waddr = item_addr;
		if (cmd.clr_we) begin
			we    = 1'b1;
			waddr = clr_q[AW-1:0];
		end else if (cmd.upd_wr && chk == obse_pkg::ST_OK) begin
			case (kind_q)
				obse_pkg::UK_ADD: begin
					we    = 1'b1;
					wdata = {1'b1, side_q, price_q, prio_q, qty_q};
				end
				obse_pkg::UK_MODIFY: begin
					we    = 1'b1;
					wdata = {rdata[97:96], price_q, rdata[63:32], qty_q};
				end
				obse_pkg::UK_CANCEL: begin
					we    = 1'b1;
					wdata = '0;
				end
				default: we = 1'b0;
			endcase
		end
	end

	obse_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign sts.clr_done  = clr_q[AW];
	assign sts.rd_valid  = rdata[97];
	assign sts.slot_last = (32'(cur_s_q) == 32'(SLOTS_PER_TICKER - 1));
	assign sts.tick_last = (32'(cur_t_q) == 32'(TICKER_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			applied_q <= '0;
			count_q   <= '0;
			cur_t_q   <= '0;
			cur_s_q   <= '0;
			clr_q     <= '0;
		end else begin
			if (cmd.clr_inc) clr_q <= clr_q + 1'b1;
			if (cmd.upd_wr && chk == obse_pkg::ST_OK) applied_q <= seq_q;
			if (cmd.emit_start) count_q <= 32'd1;
			else if (cmd.emit_clear || cmd.emit_add || cmd.emit_end) count_q <= count_q + 32'd1;
			if (cmd.cur_reset) begin
				cur_t_q <= '0;
				cur_s_q <= '0;
			end else begin
				if (cmd.tick_inc) cur_t_q <= cur_t_q + 1'b1;
				if (cmd.slot_reset) cur_s_q <= '0;
				else if (cmd.slot_inc) cur_s_q <= cur_s_q + 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.upd_resp || cmd.busy_resp || cmd.emit_start || cmd.emit_clear
				|| cmd.emit_add || cmd.emit_end) begin
			message_number <= '0;
			out_ticker     <= '0;
			out_order_slot <= '0;
			out_side       <= 1'b0;
			out_price      <= '0;
			out_quantity   <= '0;
			out_priority   <= '0;
			last_sequence  <= '0;
			status         <= obse_pkg::ST_OK;
			last           <= 1'b0;
			if (cmd.upd_resp) begin
				message_kind  <= obse_pkg::MK_STATUS;
				status        <= chk;
				last_sequence <= (chk == obse_pkg::ST_OK) ? seq_q : applied_q;
			end else if (cmd.busy_resp) begin
				message_kind  <= obse_pkg::MK_STATUS;
				status        <= obse_pkg::ST_BUSY;
				last_sequence <= applied_q;
			end else if (cmd.emit_start) begin
				message_kind  <= obse_pkg::MK_START;
				last_sequence <= applied_q;
			end else if (cmd.emit_clear) begin
				message_number <= count_q;
				message_kind   <= obse_pkg::MK_CLEAR;
				out_ticker     <= cmd.tick_inc ? 3'(cur_t_q + 1'b1) : 3'(cur_t_q);
			end else if (cmd.emit_add) begin
				message_number <= count_q;
				message_kind   <= obse_pkg::MK_ADD;
				out_ticker     <= 3'(cur_t_q);
				out_order_slot <= 10'(cur_s_q);
				out_side       <= rdata[96];
				out_price      <= rdata[95:64];
				out_priority   <= rdata[63:32];
				out_quantity   <= rdata[31:0];
			end else begin
				message_number <= count_q;
				message_kind   <= obse_pkg::MK_END;
				last_sequence  <= applied_q;
				last           <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/obse_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module obse_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_op,
	output logic                    in_stall,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    load_in,
	output obse_pkg::obse_cmd_t     cmd,
	input  wire obse_pkg::obse_sts_t sts
);
	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_UPD  = 3'd2;
	localparam logic [2:0] S_SNAP = 3'd3;
	localparam logic [2:0] S_SCAN = 3'd4;

	localparam logic [1:0] P_IDLE  = 2'd0;
	localparam logic [1:0] P_CLEAR = 2'd1;
	localparam logic [1:0] P_SCAN  = 2'd2;

	logic [2:0] state_q, state_d;
	logic [1:0] phase_q, phase_d;
	logic       ov_q, ov_d;
	logic       rd_pend_q;
	logic       out_free;

	assign out_free  = !ov_q || !out_stall;
	assign out_valid = ov_q;
	assign in_stall  = !(state_q == S_IDLE && out_free);
	assign load_in   = in_valid && !in_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		phase_d = phase_q;
		ov_d    = ov_q && out_stall;
		case (state_q)
			S_CLR: begin
				cmd.clr_we  = !sts.clr_done;
				cmd.clr_inc = !sts.clr_done;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (load_in) begin
					if (in_op) begin
						state_d = S_SNAP;
					end else if (phase_q != P_IDLE) begin
						cmd.busy_resp = 1'b1;
						ov_d          = 1'b1;
					end else begin
						cmd.rd  = 1'b1;
						state_d = S_UPD;
					end
				end
			end
			S_UPD: begin
				cmd.upd_wr   = 1'b1;
				cmd.upd_resp = 1'b1;
				ov_d         = 1'b1;
				state_d      = S_IDLE;
			end
			S_SNAP: begin
				case (phase_q)
					P_CLEAR: begin
						cmd.emit_clear = 1'b1;
						cmd.slot_reset = 1'b1;
						phase_d        = P_SCAN;
						ov_d           = 1'b1;
						state_d        = S_IDLE;
					end
					P_SCAN: begin
						cmd.use_cursor = 1'b1;
						cmd.rd         = 1'b1;
						state_d        = S_SCAN;
					end
					default: begin
						cmd.emit_start = 1'b1;
						cmd.cur_reset  = 1'b1;
						phase_d        = P_CLEAR;
						ov_d           = 1'b1;
						state_d        = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				// entry at cursor was read last cycle; cursor still points at it
				cmd.use_cursor = 1'b1;
				if (rd_pend_q && sts.rd_valid) begin
					cmd.emit_add = 1'b1;
					cmd.slot_inc = !sts.slot_last;
					if (sts.slot_last) begin
						// past the end of this ticker: park at last, next read is stale
						cmd.slot_inc = 1'b0;
					end
					ov_d    = 1'b1;
					state_d = S_IDLE;
				end else if (rd_pend_q && !sts.slot_last) begin
					cmd.slot_inc = 1'b1;
					cmd.rd       = 1'b1;
				end else if (!sts.tick_last) begin
					cmd.tick_inc   = 1'b1;
					cmd.slot_reset = 1'b1;
					cmd.emit_clear = 1'b1;
					ov_d           = 1'b1;
					state_d        = S_IDLE;
				end else begin
					cmd.emit_end  = 1'b1;
					cmd.cur_reset = 1'b1;
					phase_d       = P_IDLE;
					ov_d          = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// rd_pend marks that the cursor slot still needs looking at; cleared when an
	// add was emitted from the last slot of a ticker
	logic scan_open_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			phase_q     <= P_IDLE;
			ov_q        <= 1'b0;
			scan_open_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			ov_q    <= ov_d;
			if (cmd.emit_clear) scan_open_q <= 1'b1;
			else if (cmd.emit_add && sts.slot_last) scan_open_q <= 1'b0;
		end
	end
	assign rd_pend_q = scan_open_q;
endmodule
`default_nettype wire

// ===== src/order_book_snapshot_engine_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel | handshake             | payload
// in      | in_valid / in_stall   | opcode, update_kind, ticker, order_slot, side, price,
//         |                       | quantity, priority_req, sequence_req
// out     | out_valid / out_stall | message_number .. last (one item per input item)
//
// After reset a clearing pass writes every table entry while in_stall is held high. An
// update reads the order RAM at the taking edge and then writes it; an update during a
// snapshot answers busy. A snapshot step emits start and the first clear directly from
// the snapshot state; an add, or the clear or end that follows a scan, first reads the
// slot at the cursor and then skips empty slots one at a time, bounded by the single
// RAM read port. Items are handled one at a time: a new item is taken only once the
// previous result leaves the output register; out_stall holds it there and stalls input.
module order_book_snapshot_engine_top #(
	parameter int TICKER_COUNT = obse_pkg::TICKER_COUNT_DEF,
	parameter int SLOTS_PER_TICKER = obse_pkg::SLOTS_PER_TICKER_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        opcode,
	input  wire logic [1:0]  update_kind,
	input  wire logic [2:0]  ticker,
	input  wire logic [9:0]  order_slot,
	input  wire logic        side,
	input  wire logic [31:0] price,
	input  wire logic [31:0] quantity,
	input  wire logic [31:0] priority_req,
	input  wire logic [31:0] sequence_req,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      message_number,
	output logic [2:0]       message_kind,
	output logic [2:0]       out_ticker,
	output logic [9:0]       out_order_slot,
	output logic             out_side,
	output logic [31:0]      out_price,
	output logic [31:0]      out_quantity,
	output logic [31:0]      out_priority,
	output logic [31:0]      last_sequence,
	output logic [2:0]       status,
	output logic             last
);
	obse_pkg::obse_cmd_t cmd;
	obse_pkg::obse_sts_t sts;
	logic                load_in;

	obse_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_op(opcode),
		.in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
		.load_in(load_in), .cmd(cmd), .sts(sts)
	);

	obse_datapath #(.TICKER_COUNT(TICKER_COUNT), .SLOTS_PER_TICKER(SLOTS_PER_TICKER)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .load_in(load_in),
		.update_kind(update_kind), .ticker(ticker), .order_slot(order_slot), .side(side),
		.price(price), .quantity(quantity), .priority_req(priority_req),
		.sequence_req(sequence_req), .message_number(message_number),
		.message_kind(message_kind), .out_ticker(out_ticker),
		.out_order_slot(out_order_slot), .out_side(out_side), .out_price(out_price),
		.out_quantity(out_quantity), .out_priority(out_priority),
		.last_sequence(last_sequence), .status(status), .last(last)
	);
endmodule
`default_nettype wire
